// ===== rtl/dcf_pkg.sv =====
// Shared types, widths and constants of the dual-channel FIR low-pass filter.
package dcf_pkg;

  localparam int TAPS    = 12;
  localparam int PAIRS   = TAPS / 2;
  localparam int NUM_CH  = 2;
  localparam int TAP_W   = $clog2(TAPS);
  localparam int PAIR_W  = $clog2(PAIRS);

  localparam int SAMPLE_W = 12;
  localparam int RESULT_W = 13;
  localparam int COEF_W   = 17;
  localparam int FILL_W   = $clog2(TAPS + 1);

  typedef logic [SAMPLE_W-1:0]      sample_t;
  typedef logic [RESULT_W-1:0]      result_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [FILL_W-1:0]        fill_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = $clog2(PAIRS);
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_OUTER  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_SECOND = cfg_idx_t'(1);
  localparam cfg_idx_t REG_THIRD  = cfg_idx_t'(2);
  localparam cfg_idx_t REG_FOURTH = cfg_idx_t'(3);
  localparam cfg_idx_t REG_FIFTH  = cfg_idx_t'(4);
  localparam cfg_idx_t REG_CENTER = cfg_idx_t'(5);

  localparam coef_t COEF_RESET [PAIRS] = '{
    17'sd192, -17'sd570, -17'sd2745, -17'sd764, 17'sd11233, 17'sd25135
  };

  // Per-cycle commands from the sequencer to every lane.
  typedef struct packed {
    logic              load;  // shift in a new sample and clear the accumulator
    logic              mac;   // multiply one mirrored tap pair
    logic [PAIR_W-1:0] idx;   // which tap pair
  } lane_ctrl_t;

endpackage

// ===== rtl/dual_channel_fir_lowpass_core.sv =====
// Top level of the dual-channel 12-tap symmetric FIR low-pass filter.
// Each item carries one 12-bit sample per channel and yields one result item.
// Both channels run in parallel lanes; each lane pre-adds mirrored taps and
// walks the six coefficient pairs through one multiplier: a multiply step per
// pair, a step for the last product to reach the accumulator, then a load into
// the output register, which waits while a held result is stalled; the input
// is taken again after that load. During the first 12 items samples pass
// straight through with filter_active low. The output register holds a result
// while the next item is accepted. Coefficients are Q16; the user must write
// them via the config port only while idle; the block does not enforce this.
module dual_channel_fir_lowpass_core
  import dcf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         sample_valid,
  output logic         sample_stall,
  input  sample_t      sample_ch0,
  input  sample_t      sample_ch1,
  output logic         result_valid,
  input  logic         result_stall,
  output result_t      filtered_ch0,
  output result_t      filtered_ch1,
  output logic         filter_active,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  cfg_idx_t     cfg_index,
  input  coef_t        cfg_data
);

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t            state;
  logic [PAIR_W:0]   step;
  fill_t             fill;
  logic              active;
  coef_t             coef [PAIRS];
  lane_ctrl_t        ctrl;
  logic              accept;
  logic              out_load;
  sample_t           samp_in [NUM_CH];
  result_t           filt [NUM_CH];
  sample_t           newest [NUM_CH];
  result_t           filtered [NUM_CH];

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_load     = (state == DONE) && (!result_valid || !result_stall);

  assign ctrl.load = accept;
  assign ctrl.mac  = (state == RUN) && (step < (PAIR_W+1)'(PAIRS));
  assign ctrl.idx  = step[PAIR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAIRS; i++) begin
        coef[i] <= COEF_RESET[i];
      end
    end else if (cfg_valid && cfg_ready && cfg_index <= REG_CENTER) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      step   <= '0;
      fill   <= '0;
      active <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            active <= (fill == FILL_W'(TAPS));
            if (fill != FILL_W'(TAPS)) begin
              fill  <= fill + 1'b1;
              state <= DONE;
            end else begin
              state <= RUN;
            end
            step <= '0;
          end
        end
        RUN: begin
          // The last step only lets the final product reach the accumulator.
          if (step == (PAIR_W+1)'(PAIRS)) begin
            state <= DONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        DONE: begin
          if (out_load) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign samp_in[0] = sample_ch0;
  assign samp_in[1] = sample_ch1;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    dcf_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .sample (samp_in[c]),
      .coef   (coef),
      .filt   (filt[c]),
      .newest (newest[c])
    );
  end

  dcf_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (out_load),
    .active        (active),
    .filt          (filt),
    .newest        (newest),
    .result_stall  (result_stall),
    .result_valid  (result_valid),
    .filtered      (filtered),
    .filter_active (filter_active)
  );

  assign filtered_ch0 = filtered[0];
  assign filtered_ch1 = filtered[1];

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(TAPS))
    else $error("fill count beyond tap count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(result_valid && result_stall))
    else $error("held result overwritten");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != IDLE))
    else $error("sequencer idle right after an accepted item");

  a_active_only_full: assert property (@(posedge clk) disable iff (rst)
    (out_load && active) |-> (fill == FILL_W'(TAPS)))
    else $error("filtered result before the delay line is full");

endmodule

// ===== rtl/dcf_lane.sv =====
// One channel lane: 12-sample delay line and a shared multiply-accumulate over tap pairs.
module dcf_lane
  import dcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lane_ctrl_t ctrl,
  input  sample_t    sample,
  input  coef_t      coef [PAIRS],
  output result_t    filt,
  output sample_t    newest
);

  localparam int PROD_W = SAMPLE_W + 2 + COEF_W;
  localparam int ACC_W  = PROD_W + 3;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Tap 0 is the oldest sample, the last tap the newest.
  sample_t taps [TAPS];
  prod_t   prod;
  logic    prod_valid;
  acc_t    acc;

  logic [TAP_W-1:0]  lo_idx;
  logic [TAP_W-1:0]  hi_idx;
  logic [SAMPLE_W:0] pair;

  function automatic result_t round_clamp(acc_t a);
    acc_t                 rnd;
    logic [ACC_W-16-1:0]  q;
    rnd = a + acc_t'(32768);
    q   = rnd[ACC_W-1:16];
    if (rnd < 0) begin
      return '0;
    end else if (q > (ACC_W-16)'({RESULT_W{1'b1}})) begin
      return '1;
    end else begin
      return q[RESULT_W-1:0];
    end
  endfunction

  assign lo_idx = {{(TAP_W-PAIR_W){1'b0}}, ctrl.idx};
  assign hi_idx = TAP_W'(TAPS - 1) - lo_idx;
  assign pair   = {1'b0, taps[lo_idx]} + {1'b0, taps[hi_idx]};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        taps[i] <= taps[i+1];
      end
      taps[TAPS-1] <= sample;
    end
    if (ctrl.mac) begin
      prod <= $signed({1'b0, pair}) * coef[ctrl.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      acc        <= '0;
    end else begin
      prod_valid <= ctrl.mac;
      if (ctrl.load) begin
        acc <= '0;
      end else if (prod_valid) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  assign filt   = round_clamp(acc);
  assign newest = taps[TAPS-1];

endmodule

// ===== rtl/dcf_merge.sv =====
// Output stage: gathers the lane results into one held result item.
module dcf_merge
  import dcf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  logic    active,
  input  result_t filt [NUM_CH],
  input  sample_t newest [NUM_CH],
  input  logic    result_stall,
  output logic    result_valid,
  output result_t filtered [NUM_CH],
  output logic    filter_active
);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // During warm-up the newest sample of each lane passes straight through.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int c = 0; c < NUM_CH; c++) begin
        filtered[c] <= active ? filt[c] : {1'b0, newest[c]};
      end
      filter_active <= active;
    end
  end

endmodule

// ===== tb/dual_channel_fir_lowpass_core_test.sv =====
// Self-checking testbench for the dual-channel 12-tap symmetric FIR low-pass core.
`timescale 1ns / 1ps

module dual_channel_fir_lowpass_core_test
  import dcf_pkg::*;
;

  localparam coef_t COEF_MIN = coef_t'(17'h10000);
  localparam coef_t COEF_MAX = coef_t'(17'h0FFFF);
  localparam int ITEMS_PER_PHASE = 250;

  typedef struct packed {
    result_t ch0;
    result_t ch1;
    logic    active;
  } fir_out_t;

  typedef struct packed {
    sample_t  s0;
    sample_t  s1;
    logic     typed;
    fir_out_t want;
  } directed_row_t;

  typedef enum int {COEF_MODERATE, COEF_LOWEST, COEF_HIGHEST, COEF_WILD, COEF_DEFAULT}
    coef_mode_t;

  // The first twelve rows are warm-up passthrough, so their results are the samples.
  localparam directed_row_t DIRECTED_ROWS [25] = '{
    '{12'h000, 12'hFFF, 1'b1, '{13'h0000, 13'h0FFF, 1'b0}},
    '{12'hFFF, 12'h000, 1'b1, '{13'h0FFF, 13'h0000, 1'b0}},
    '{12'hAAA, 12'h555, 1'b1, '{13'h0AAA, 13'h0555, 1'b0}},
    '{12'h555, 12'hAAA, 1'b1, '{13'h0555, 13'h0AAA, 1'b0}},
    '{12'h001, 12'hFFE, 1'b1, '{13'h0001, 13'h0FFE, 1'b0}},
    '{12'h800, 12'h7FF, 1'b1, '{13'h0800, 13'h07FF, 1'b0}},
    '{12'h7FF, 12'h800, 1'b1, '{13'h07FF, 13'h0800, 1'b0}},
    '{12'h000, 12'h000, 1'b1, '{13'h0000, 13'h0000, 1'b0}},
    '{12'hFFF, 12'hFFF, 1'b1, '{13'h0FFF, 13'h0FFF, 1'b0}},
    '{12'h123, 12'hEDC, 1'b1, '{13'h0123, 13'h0EDC, 1'b0}},
    '{12'hFFF, 12'h000, 1'b1, '{13'h0FFF, 13'h0000, 1'b0}},
    '{12'h000, 12'hFFF, 1'b1, '{13'h0000, 13'h0FFF, 1'b0}},
    '{12'hFFF, 12'hFFF, 1'b0, '{13'h0000, 13'h0000, 1'b0}},
    '{12'h000, 12'h000, 1'b0, '{13'h0000, 13'h0000, 1'b0}},
    '{12'hFFF, 12'h000, 1'b0, '{13'h0000, 13'h0000, 1'b0}},
    '{12'h000, 12'hFFF, 1'b0, '{13'h0000, 13'h0000, 1'b0}},
    '{12'hAAA, 12'h555, 1'b0, '{13'h0000, 13'h0000, 1'b0}},
    '{12'h555, 12'hAAA, 1'b0, '{13'h0000, 13'h0000, 1'b0}},
    '{12'hFFF, 12'hFFF, 1'b0, '{13'h0000, 13'h0000, 1'b0}},
    '{12'hFFF, 12'hFFF, 1'b0, '{13'h0000, 13'h0000, 1'b0}},
    '{12'h001, 12'h001, 1'b0, '{13'h0000, 13'h0000, 1'b0}},
    '{12'h800, 12'h800, 1'b0, '{13'h0000, 13'h0000, 1'b0}},
    '{12'h000, 12'h000, 1'b0, '{13'h0000, 13'h0000, 1'b0}},
    '{12'hFFF, 12'hFFF, 1'b0, '{13'h0000, 13'h0000, 1'b0}},
    '{12'h7FF, 12'h7FF, 1'b0, '{13'h0000, 13'h0000, 1'b0}}
  };

  logic     clk;
  logic     rst;
  logic     sample_valid;
  logic     sample_stall;
  sample_t  sample_ch0;
  sample_t  sample_ch1;
  logic     result_valid;
  logic     result_stall;
  result_t  filtered_ch0;
  result_t  filtered_ch1;
  logic     filter_active;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  coef_t    cfg_data;

  // Predictor state: coefficients, per-channel sample rings, ring position, warm-up count.
  coef_t    coef_bank [PAIRS];
  sample_t  tap_ring [NUM_CH][TAPS];
  int       ring_pos;
  int       rounds_seen;
  fir_out_t expected_outputs [$];
  int       errors;
  bit       steady_flow;

  dual_channel_fir_lowpass_core dut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample_ch0    (sample_ch0),
    .sample_ch1    (sample_ch1),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .filtered_ch0  (filtered_ch0),
    .filtered_ch1  (filtered_ch1),
    .filter_active (filter_active),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Oldest sample is tap 0; mirrored taps share one coefficient.
  function automatic result_t lowpass_sum(input int ch);
    longint acc;
    int     pos;
    int     m;
    acc = 0;
    pos = ring_pos + 1;
    for (int k = 0; k < TAPS; k++) begin
      if (pos >= TAPS) pos = 0;
      m = (k < PAIRS) ? k : TAPS - 1 - k;
      acc += longint'(tap_ring[ch][pos]) * longint'(coef_bank[m]);
      pos++;
    end
    acc += 32768;
    if (acc < 0) return '0;
    acc = acc / 65536;
    if (acc > 8191) return result_t'(8191);
    return result_t'(acc);
  endfunction

  function automatic fir_out_t filter_round(input sample_t a, input sample_t b);
    fir_out_t r;
    // Warm-up looks at the count before this round is added.
    r.active = (rounds_seen >= TAPS);
    tap_ring[0][ring_pos] = a;
    tap_ring[1][ring_pos] = b;
    r.ch0 = r.active ? lowpass_sum(0) : result_t'(a);
    r.ch1 = r.active ? lowpass_sum(1) : result_t'(b);
    ring_pos = (ring_pos + 1) % TAPS;
    if (rounds_seen < TAPS) rounds_seen++;
    return r;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Leaves sample_valid high after the item is taken; the caller lowers it or sends on.
  task automatic send_round(input sample_t a, input sample_t b, input logic typed,
                            input fir_out_t given);
    fir_out_t want;
    if (!steady_flow && $urandom_range(99) < 17) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_ch0   <= a;
    sample_ch1   <= b;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    want = filter_round(a, b);
    expected_outputs.push_back(typed ? given : want);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_round(pick_sample(), pick_sample(), 1'b0, '0);
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need only one assignment per step.
  task automatic write_coef(input cfg_idx_t idx, input coef_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // Indexes past the last coefficient are ignored by the block.
    if (idx < PAIRS) coef_bank[idx] = val;
  endtask

  task automatic reprogram(input coef_mode_t mode);
    coef_t val;
    wait_drained();
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      case (mode)
        COEF_MODERATE: val = coef_t'(int'($urandom_range(40000)) - 8000);
        COEF_LOWEST:   val = COEF_MIN;
        COEF_HIGHEST:  val = COEF_MAX;
        COEF_WILD:     val = coef_t'($urandom);
        default:       val = (i < PAIRS) ? COEF_RESET[i] : coef_t'($urandom);
      endcase
      if (i < PAIRS || mode == COEF_WILD || mode == COEF_DEFAULT)
        write_coef(cfg_idx_t'(i), val);
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    result_stall <= !steady_flow && ($urandom_range(99) < 17);
  end

  always @(posedge clk) begin
    fir_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item: ch0 %0d ch1 %0d active %0b", $time,
                 filtered_ch0, filtered_ch1, filter_active);
      end else begin
        want = expected_outputs.pop_front();
        if (filtered_ch0 !== want.ch0) begin
          errors++;
          $display("%0t: filtered_ch0 expected %0d, actual %0d", $time, want.ch0, filtered_ch0);
        end
        if (filtered_ch1 !== want.ch1) begin
          errors++;
          $display("%0t: filtered_ch1 expected %0d, actual %0d", $time, want.ch1, filtered_ch1);
        end
        if (filter_active !== want.active) begin
          errors++;
          $display("%0t: filter_active expected %0b, actual %0b", $time, want.active,
                   filter_active);
        end
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample_ch0   <= '0;
    sample_ch1   <= '0;
    result_stall <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    errors      = 0;
    steady_flow = 1'b0;
    ring_pos    = 0;
    rounds_seen = 0;
    for (int i = 0; i < PAIRS; i++) coef_bank[i] = COEF_RESET[i];
    foreach (tap_ring[c, k]) tap_ring[c][k] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      send_round(DIRECTED_ROWS[i].s0, DIRECTED_ROWS[i].s1, DIRECTED_ROWS[i].typed,
                 DIRECTED_ROWS[i].want);
    send_random(ITEMS_PER_PHASE);

    // Long stretch with neither side idling.
    steady_flow = 1'b1;
    send_random(ITEMS_PER_PHASE);
    steady_flow = 1'b0;

    reprogram(COEF_MODERATE);
    send_random(ITEMS_PER_PHASE);
    // All coefficients at the negative extreme drive sums below zero, so outputs clamp.
    reprogram(COEF_LOWEST);
    send_random(ITEMS_PER_PHASE);
    // All coefficients at the positive extreme push outputs into saturation.
    reprogram(COEF_HIGHEST);
    send_random(ITEMS_PER_PHASE);
    reprogram(COEF_WILD);
    send_random(ITEMS_PER_PHASE);
    reprogram(COEF_DEFAULT);
    send_random(ITEMS_PER_PHASE);

    wait_drained();
    repeat (30) @(posedge clk);
    if (errors == 0 && expected_outputs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
